### design/buls_pkg.sv
// Shared constants, types and address helpers for the banked load/store unit.
`default_nettype none

package buls_pkg;

  // Geometry
  localparam int BANK_COUNT   = 4;
  localparam int ADDRESS_BITS = 8;

  localparam int ADDR_W    = ADDRESS_BITS;
  localparam int WORD_W    = ADDR_W - 2;
  localparam int MEM_WORDS = 2 ** WORD_W;
  localparam int BANK_W    = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
  localparam int BANK_ROWS = (MEM_WORDS + BANK_COUNT - 1) / BANK_COUNT;
  localparam int ROW_W     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;

  // Payload widths fixed by the interface
  localparam int CMD_W  = 3;
  localparam int BADDR_W = 8;
  localparam int DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LW = 3'd0,
    CMD_LH = 3'd1,
    CMD_LB = 3'd2,
    CMD_SW = 3'd3,
    CMD_SH = 3'd4,
    CMD_SB = 3'd5
  } cmd_e;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request and read both banks
    logic commit;   // merge, write back, load output register
  } buls_cmd_t;

  function automatic logic [BANK_W-1:0] bank_of(input logic [WORD_W-1:0] word);
    return BANK_W'(word % BANK_COUNT);
  endfunction

  function automatic logic [ROW_W-1:0] row_of(input logic [WORD_W-1:0] word);
    return ROW_W'(word / BANK_COUNT);
  endfunction

endpackage

`default_nettype wire

### design/buls_ctrl.sv
// Controller state machine and output valid flag for the banked load/store unit.
`default_nettype none

module buls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output buls_pkg::buls_cmd_t cmd_o
);
  import buls_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_ACCESS = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   capture, commit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign capture    = in_valid_i && in_ready_o;
  // Finish only when the output register is free or being emptied
  assign commit     = (state_q == ST_ACCESS) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (capture) state_d = ST_ACCESS;
      end
      ST_ACCESS: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.commit  = commit;

endmodule

`default_nettype wire

### design/buls_dpath.sv
// Datapath: word banks, two-word read, byte merge and load alignment.
`default_nettype none

module buls_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  buls_pkg::buls_cmd_t                cmd_i,
  input  logic [buls_pkg::CMD_W-1:0]         command_i,
  input  logic [buls_pkg::BADDR_W-1:0]       byte_address_i,
  input  logic [buls_pkg::DATA_W-1:0]        write_value_i,
  output logic [buls_pkg::DATA_W-1:0]        read_value_o
);
  import buls_pkg::*;

  // Storage
  logic [DATA_W-1:0]    mem_q   [BANK_COUNT][BANK_ROWS];
  logic [BANK_ROWS-1:0] vld_q   [BANK_COUNT];
  logic [DATA_W-1:0]    rdata_q [BANK_COUNT];
  logic [BANK_COUNT-1:0] rvld_q;

  // Latched request
  logic [CMD_W-1:0]  command_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wval_q;
  logic [DATA_W-1:0] read_value_q;

  // Read addressing from the incoming request
  logic [ADDR_W-1:0] in_addr;
  logic [WORD_W-1:0] in_w0, in_w1;
  logic [ROW_W-1:0]  rrow [BANK_COUNT];

  // Addressing of the held request
  logic [WORD_W-1:0] w0, w1;
  logic [BANK_W-1:0] bank0, bank1;
  logic [ROW_W-1:0]  row0, row1;

  logic [2:0]        count;
  logic              is_store;
  logic [1:0]        pad;
  logic [4:0]        off_sh, pad_sh;
  logic [DATA_W-1:0] word0, word1;
  logic [2*DATA_W-1:0] pair, pair_al, mask, wdata_al, pair_new;
  logic              en0, en1;
  logic [DATA_W-1:0] result;

  logic              we    [BANK_COUNT];
  logic [ROW_W-1:0]  wrow  [BANK_COUNT];
  logic [DATA_W-1:0] wdata [BANK_COUNT];

  assign in_addr = ADDR_W'(byte_address_i);
  assign in_w0   = in_addr[ADDR_W-1:2];
  assign in_w1   = in_w0 + 1'b1;

  always_comb begin
    for (int b = 0; b < BANK_COUNT; b++) begin
      rrow[b] = (bank_of(in_w0) == BANK_W'(b)) ? row_of(in_w0) : row_of(in_w1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      command_q <= command_i;
      addr_q    <= in_addr;
      wval_q    <= write_value_i;
    end
    if (cmd_i.commit) read_value_q <= result;
  end

  assign w0    = addr_q[ADDR_W-1:2];
  assign w1    = w0 + 1'b1;
  assign bank0 = bank_of(w0);
  assign bank1 = bank_of(w1);
  assign row0  = row_of(w0);
  assign row1  = row_of(w1);

  // Decode size and direction
  always_comb begin
    case (cmd_e'(command_q)) inside
      CMD_LW, CMD_SW: count = 3'd4;
      CMD_LH, CMD_SH: count = 3'd2;
      CMD_LB, CMD_SB: count = 3'd1;
      default:        count = 3'd0;
    endcase
  end

  always_comb begin
    case (cmd_e'(command_q)) inside
      CMD_SW, CMD_SH, CMD_SB: is_store = 1'b1;
      default:                is_store = 1'b0;
    endcase
  end

  // Unwritten rows read as zero
  assign word0 = rvld_q[bank0] ? rdata_q[bank0] : '0;
  assign word1 = rvld_q[bank1] ? rdata_q[bank1] : '0;
  assign pair  = {word0, word1};

  assign pad    = 2'(3'd4 - count);
  assign pad_sh = {pad, 3'b000};
  assign off_sh = {addr_q[1:0], 3'b000};

  assign pair_al  = pair << off_sh;
  assign mask     = {({DATA_W{1'b1}} << pad_sh), {DATA_W{1'b0}}} >> off_sh;
  assign wdata_al = {(wval_q << pad_sh), {DATA_W{1'b0}}} >> off_sh;
  assign pair_new = (pair & ~mask) | (wdata_al & mask);
  assign en0      = |mask[2*DATA_W-1:DATA_W];
  assign en1      = |mask[DATA_W-1:0];

  always_comb begin
    result = '0;
    if (!is_store && (count != 3'd0)) result = pair_al[2*DATA_W-1:DATA_W] >> pad_sh;
  end

  always_comb begin
    for (int b = 0; b < BANK_COUNT; b++) begin
      we[b]    = 1'b0;
      wrow[b]  = row1;
      wdata[b] = pair_new[DATA_W-1:0];
      if (bank0 == BANK_W'(b)) begin
        we[b]    = cmd_i.commit && is_store && en0;
        wrow[b]  = row0;
        wdata[b] = pair_new[2*DATA_W-1:DATA_W];
      end else if (bank1 == BANK_W'(b)) begin
        we[b]    = cmd_i.commit && is_store && en1;
      end
    end
  end

  // One write and one read port per bank
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < BANK_COUNT; b++) begin
      if (we[b]) mem_q[b][wrow[b]] <= wdata[b];
      if (cmd_i.capture) rdata_q[b] <= mem_q[b][rrow[b]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BANK_COUNT; b++) vld_q[b] <= '0;
      rvld_q <= '0;
    end else begin
      for (int b = 0; b < BANK_COUNT; b++) begin
        if (we[b]) vld_q[b][wrow[b]] <= 1'b1;
        if (cmd_i.capture) rvld_q[b] <= vld_q[b][rrow[b]];
      end
    end
  end

  assign read_value_o = read_value_q;

endmodule

`default_nettype wire

### design/banked_unaligned_load_store.sv
// Top level of the banked unaligned big-endian load/store unit.
//
// Byte-addressed big-endian memory of 2^ADDRESS_BITS bytes, stored as 32-bit
// words spread over BANK_COUNT interleaved banks (bank = word index mod
// BANK_COUNT, row = word index / BANK_COUNT). Each request loads or stores a
// word, halfword or byte at any byte address; the addressed byte is the most
// significant one. An access that runs past a word boundary continues in the
// next word, which always lives in another bank, so both words are read in
// the same cycle; past the top of memory it wraps to address 0. Loads return
// zero-extended data, stores return zero and change only the addressed bytes,
// and commands 6 and 7 return zero and leave memory alone. Memory reads as
// zero after reset: a valid bit per row stands in for a clearing pass, so the
// block takes requests right after reset. Each request is handled in a capture
// step, which latches it and reads both bank words, then a commit step, which
// merges or aligns and writes back into the banks; the commit step is held
// while the output register holds a result not yet taken. A new request
// is accepted as soon as the previous one has moved into the output register,
// so one result can wait at the output while the next request is at work.
`default_nettype none

module banked_unaligned_load_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [buls_pkg::CMD_W-1:0]    command_i,
  input  logic [buls_pkg::BADDR_W-1:0]  byte_address_i,
  input  logic [buls_pkg::DATA_W-1:0]   write_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [buls_pkg::DATA_W-1:0]   read_value_o
);
  import buls_pkg::*;

  buls_cmd_t cmd;

  // Sequence each request: capture, then commit once the output is free
  buls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold the banks, read both words, merge stores and align loads
  buls_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .command_i      (command_i),
    .byte_address_i (byte_address_i),
    .write_value_i  (write_value_i),
    .read_value_o   (read_value_o)
  );

endmodule

`default_nettype wire

### design/buls_checker.sv
// Port-level checks for the banked load/store unit and their bind.
`default_nettype none

module buls_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic [buls_pkg::CMD_W-1:0]    command_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [buls_pkg::DATA_W-1:0]   read_value_o
);
  import buls_pkg::*;

  logic in_acc, is_store_req;

  assign in_acc       = in_valid_i && in_ready_o;
  assign is_store_req = (command_i == CMD_SW) || (command_i == CMD_SH) ||
                        (command_i == CMD_SB);

  // One request at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request accepted while previous one still at work");

  // A request finishes the cycle after capture when the output is free
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("result missing after request");

  // Stores report zero
  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_store_req) ##1 (!out_valid_o || out_ready_i) |=>
      (read_value_o == '0))
    else $error("store returned nonzero data");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(read_value_o)))
    else $error("stalled result dropped or changed");

endmodule

bind banked_unaligned_load_store buls_checker u_buls_checker (.*);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench for the banked unaligned load/store unit: directed table plus random requests.

module tb;
  import buls_pkg::*;

  // Commands 6 and 7 have no enum member: they return zero and leave memory alone
  localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 360;
  localparam int PHASE_COUNT      = 5;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int MAX_REPORTS      = 10;
  localparam int SETTLE_CYCLES    = 10;

  // Sender idle and receiver stall, in percent, per random phase; the last phase
  // also holds the receiver off for a long stretch to back the block up.
  localparam int PHASE_IDLE  [PHASE_COUNT] = '{0, 84, 0, 28, 0};
  localparam int PHASE_STALL [PHASE_COUNT] = '{0, 0, 84, 28, 0};

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BADDR_W-1:0] addr;
    logic [DATA_W-1:0]  data;
    logic               typed;  // expected value below is used as is
    logic [DATA_W-1:0]  want;
  } table_row_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BADDR_W-1:0] addr;
    logic [DATA_W-1:0]  value;
  } awaited_read_t;

  // Directed requests: empty-memory reads, crossings at the top of memory, word and
  // row boundaries, aligned halves, unused commands, all-zero and all-one data.
  localparam int DIRECTED_COUNT = 25;
  localparam table_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{CMD_LW,   8'h00, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_LB,   8'hFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_LH,   8'hFF, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_SW,   8'h00, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{CMD_LW,   8'h00, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{CMD_SW,   8'hFE, 32'h1122_3344, 1'b1, 32'h0000_0000},
    '{CMD_LW,   8'hFE, 32'h0000_0000, 1'b1, 32'h1122_3344},
    '{CMD_LW,   8'h00, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_SH,   8'h05, 32'hABCD_1234, 1'b1, 32'h0000_0000},
    '{CMD_LW,   8'h04, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_SH,   8'h07, 32'h0000_BEEF, 1'b1, 32'h0000_0000},
    '{CMD_LH,   8'h07, 32'h0000_0000, 1'b1, 32'h0000_BEEF},
    '{CMD_SB,   8'hFF, 32'hFFFF_FF5A, 1'b1, 32'h0000_0000},
    '{CMD_LB,   8'hFF, 32'h0000_0000, 1'b1, 32'h0000_005A},
    '{CMD_LH,   8'hFF, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_RSV6, 8'h80, 32'hDEAD_BEEF, 1'b1, 32'h0000_0000},
    '{CMD_RSV7, 8'h7F, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{CMD_LW,   8'h80, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_SW,   8'hFD, 32'hA5A5_A5A5, 1'b1, 32'h0000_0000},
    '{CMD_LW,   8'hFF, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_SW,   8'h0F, 32'h0102_0304, 1'b1, 32'h0000_0000},
    '{CMD_LW,   8'h0F, 32'h0000_0000, 1'b1, 32'h0102_0304},
    '{CMD_SH,   8'h3E, 32'h0000_FFFF, 1'b1, 32'h0000_0000},
    '{CMD_LW,   8'h3C, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_SB,   8'h10, 32'h0000_0000, 1'b1, 32'h0000_0000}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [CMD_W-1:0]   command_i;
  logic [BADDR_W-1:0] byte_address_i;
  logic [DATA_W-1:0]  write_value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [DATA_W-1:0]  read_value_o;

  // Byte image of the memory, big-endian within each word
  logic [DATA_W-1:0] mem_image [MEM_WORDS];
  awaited_read_t     awaited_reads [$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_off_asked;
  int hold_off_seen;
  int hold_off_left;
  int mismatches;
  int cycle_count;

  banked_unaligned_load_store u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .byte_address_i (byte_address_i),
    .write_value_i  (write_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_value_o   (read_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] peek_byte(input logic [BADDR_W-1:0] a);
    return mem_image[a[BADDR_W-1:2]][8*(3-a[1:0]) +: 8];
  endfunction

  task automatic poke_byte(input logic [BADDR_W-1:0] a, input logic [7:0] v);
    mem_image[a[BADDR_W-1:2]][8*(3-a[1:0]) +: 8] = v;
  endtask

  // Apply one request to the memory image and return the value it reads back.
  // Byte addresses wrap in 8 bits, so crossings past the top land at address 0.
  task automatic run_access(input logic [CMD_W-1:0] cmd, input logic [BADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] result);
    int               nbytes;
    logic             is_store;
    logic [BADDR_W-1:0] a;
    result   = '0;
    nbytes   = 0;
    is_store = 1'b0;
    case (cmd)
      CMD_LW: nbytes = 4;
      CMD_LH: nbytes = 2;
      CMD_LB: nbytes = 1;
      CMD_SW: begin
        nbytes = 4;
        is_store = 1'b1;
      end
      CMD_SH: begin
        nbytes = 2;
        is_store = 1'b1;
      end
      CMD_SB: begin
        nbytes = 1;
        is_store = 1'b1;
      end
      default: nbytes = 0;
    endcase
    for (int i = 0; i < nbytes; i++) begin
      a = addr + BADDR_W'(i);
      if (is_store) begin
        poke_byte(a, 8'(data >> (8 * (nbytes - 1 - i))));
      end else begin
        result = {result[DATA_W-9:0], peek_byte(a)};
      end
    end
  endtask

  // Offer one request, hold it until accepted, then record what it must return
  task automatic offer(input logic [CMD_W-1:0] cmd, input logic [BADDR_W-1:0] addr,
                       input logic [DATA_W-1:0] data, input logic typed,
                       input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    byte_address_i <= addr;
    write_value_i  <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    run_access(cmd, addr, data, predicted);
    awaited_reads.push_back('{cmd: cmd, addr: addr, value: typed ? want : predicted});
  endtask

  // Random requests: addresses lean toward word ends, the top of memory and the
  // last address used, so stores are read back and crossings come often.
  task automatic offer_random(input int count);
    logic [CMD_W-1:0]   cmd;
    logic [BADDR_W-1:0] addr;
    logic [BADDR_W-1:0] last_addr;
    logic [DATA_W-1:0]  data;
    last_addr = '0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 4) begin
        cmd = $urandom_range(1) ? CMD_RSV6 : CMD_RSV7;
      end else begin
        cmd = CMD_W'($urandom_range(5));
      end
      case ($urandom_range(4))
        0: addr = last_addr;
        1: addr = BADDR_W'(252 + $urandom_range(3));
        2: addr = {6'($urandom), 2'($urandom_range(3, 1))};
        default: addr = BADDR_W'($urandom);
      endcase
      case ($urandom_range(9))
        0: data = '0;
        1: data = '1;
        default: data = DATA_W'($urandom);
      endcase
      last_addr = addr;
      offer(cmd, addr, data, 1'b0, '0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain_reads();
    while (awaited_reads.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: stall at random, or hold off for a long stretch when asked
  initial begin
    out_ready_i   = 1'b0;
    hold_off_seen = 0;
    hold_off_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_ready_i <= 1'b0;
        hold_off_left--;
      end else if (hold_off_asked != hold_off_seen) begin
        hold_off_seen = hold_off_asked;
        hold_off_left = HOLD_OFF_CYCLES - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Check each returned read against the oldest one awaited
  always @(posedge clk_i) begin : check_read
    awaited_read_t head;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result %h at cycle %0d", read_value_o, cycle_count);
        end
      end else begin
        head = awaited_reads.pop_front();
        if (read_value_o !== head.value) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch cmd %0d addr %h: read_value expected %h, got %h",
                     head.cmd, head.addr, head.value, read_value_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** banked_unaligned_load_store: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    command_i          = '0;
    byte_address_i     = '0;
    write_value_i      = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_off_asked     = 0;
    mismatches         = 0;
    cycle_count        = 0;
    for (int w = 0; w < MEM_WORDS; w++) mem_image[w] = '0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table with no idling
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      offer(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].addr, DIRECTED_ROWS[r].data,
            DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain_reads();

    // Random phases; the sender pauses between them until every read is back
    for (int p = 0; p < PHASE_COUNT; p++) begin
      sender_idle_pct    = PHASE_IDLE[p];
      receiver_stall_pct = PHASE_STALL[p];
      if (p == PHASE_COUNT - 1) hold_off_asked++;
      offer_random(RANDOM_PER_PHASE);
      drain_reads();
    end

    // Let any stray result show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** banked_unaligned_load_store: PASSED **");
    end else begin
      $display("** banked_unaligned_load_store: FAILED **");
    end
    $finish;
  end

endmodule

### banked_unaligned_load_store.f
design/buls_pkg.sv
design/buls_ctrl.sv
design/buls_dpath.sv
design/banked_unaligned_load_store.sv
design/buls_checker.sv
bench/tb.sv
